// ----- rtl/pgr_pkg.sv -----
package pgr_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int TIME_BITS_DEF   = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DOUBLE_WINDOW = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DOUBLE_BOX    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DRAG_DISTANCE = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REPEAT_DELAY  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REPEAT_PERIOD = 3'd4;

    localparam logic [15:0] DOUBLE_WINDOW_RST = 16'd500;
    localparam logic [7:0]  DOUBLE_BOX_RST    = 8'd4;
    localparam logic [7:0]  DRAG_DISTANCE_RST = 8'd4;
    localparam logic [15:0] REPEAT_DELAY_RST  = 16'd500;
    localparam logic [15:0] REPEAT_PERIOD_RST = 16'd33;

    // input commands
    localparam logic [2:0] CMD_PRESS   = 3'd0;
    localparam logic [2:0] CMD_RELEASE = 3'd1;
    localparam logic [2:0] CMD_MOVE    = 3'd2;
    localparam logic [2:0] CMD_TICK    = 3'd3;
    localparam logic [2:0] CMD_CANCEL  = 3'd4;
    localparam logic [2:0] CMD_IGNORE  = 3'd5;

    // gesture codes
    localparam logic [2:0] G_PRESS       = 3'd0;
    localparam logic [2:0] G_REPEAT      = 3'd1;
    localparam logic [2:0] G_CLICK       = 3'd2;
    localparam logic [2:0] G_DRAG_START  = 3'd3;
    localparam logic [2:0] G_DROP        = 3'd4;
    localparam logic [2:0] G_DRAG_CANCEL = 3'd5;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // queue entry: two-result flag, two results of 6 + 2c bits, end position
    function automatic int entry_bits(input int c);
        return 13 + 6 * c;
    endfunction

endpackage

// ----- rtl/pointer_gesture_recognizer_unit.sv -----
// Pointer gesture recognizer: raw pointer events in, gestures out.
// Input channel s_*: one item per event; s_tuser carries the command,
// s_tdata the button, position and millisecond timestamp.
// Output channel m_*: gesture items; m_tuser is the gesture code, m_tlast marks
// the final gesture caused by one input item. An input item causes zero, one
// or two gestures (two only for a press that interrupts a drag).
// Configuration channel cfg_*: register index and data, always ready; write
// only while the block is idle.
// Throughput: one input item per cycle while the output side keeps up. The
// front end decides all gestures for an item combinationally and writes them
// as one entry into a small queue; the back end sends one gesture per cycle while
// m_tready is high, so an item with two gestures holds the output until both go.
// Output path: an item taken at the input is written into the queue, and m_tvalid
// rises once the back end has loaded its first gesture from the queue into the
// output register; a second gesture is loaded when the first is taken.
// Receiver stall: the output register holds its item, the queue fills, and
// s_tready drops once the queue is full. No item is lost.
// Reset (aresetn low, synchronous): gesture state and queue are cleared and
// the configuration registers return to their defaults.
module pointer_gesture_recognizer_unit #(
    parameter int COORD_BITS  = pgr_pkg::COORD_BITS_DEF,
    parameter int TIME_BITS   = pgr_pkg::TIME_BITS_DEF,
    parameter int QUEUE_DEPTH = pgr_pkg::QUEUE_DEPTH_DEF,
    localparam int S_DATA_W   = ((2 + 2 * COORD_BITS + TIME_BITS + 7) / 8) * 8,
    localparam int M_DATA_W   = ((3 + 4 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [2:0]                          s_tuser,   // command
    input  logic [S_DATA_W-1:0]                 s_tdata,   // button, x_position,
                                                           // y_position, event_time
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [2:0]                          m_tuser,   // gesture
    output logic [M_DATA_W-1:0]                 m_tdata,   // which_button, is_double,
                                                           // start_x, start_y, end_x, end_y
    output logic                                m_tlast,   // last_result
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pgr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [pgr_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import pgr_pkg::*;

    localparam int EW     = entry_bits(COORD_BITS);
    localparam int X_LO   = 2;
    localparam int Y_LO   = X_LO + COORD_BITS;
    localparam int T_LO   = Y_LO + COORD_BITS;

    q_status_t             q_status;
    logic                  push, pop;
    logic [EW-1:0]         push_data, pop_data;
    logic [1:0]            which_button;
    logic                  is_double;
    logic [COORD_BITS-1:0] start_x, start_y, end_x, end_y;

    assign cfg_ready = 1'b1;

    pgr_front #(
        .COORD_BITS (COORD_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .command    (s_tuser),
        .button     (s_tdata[1:0]),
        .x_position (s_tdata[X_LO +: COORD_BITS]),
        .y_position (s_tdata[Y_LO +: COORD_BITS]),
        .event_time (s_tdata[T_LO +: TIME_BITS]),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_status   (q_status),
        .push       (push),
        .push_data  (push_data)
    );

    pgr_queue #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    pgr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_status     (q_status),
        .pop_data     (pop_data),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tlast      (m_tlast),
        .gesture      (m_tuser),
        .which_button (which_button),
        .is_double    (is_double),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y)
    );

    assign m_tdata = M_DATA_W'({end_y, end_x, start_y, start_x, is_double, which_button});

endmodule

// ----- rtl/pgr_queue.sv -----
module pgr_queue #(
    parameter int WIDTH = 85,
    parameter int DEPTH = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  logic [WIDTH-1:0]      push_data,
    input  logic                  pop,
    output logic [WIDTH-1:0]      pop_data,
    output pgr_pkg::q_status_t    status
);
    import pgr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("queue count above depth");
    a_push_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not grow queue");
    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        status.empty |-> wr_ptr_reg == rd_ptr_reg)
        else $error("empty queue with pointers apart");
`endif

endmodule

// ----- rtl/pgr_front.sv -----
module pgr_front #(
    parameter int COORD_BITS = 12,
    parameter int TIME_BITS  = 32
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [2:0]                              command,
    input  logic [1:0]                              button,
    input  logic [COORD_BITS-1:0]                   x_position,
    input  logic [COORD_BITS-1:0]                   y_position,
    input  logic [TIME_BITS-1:0]                    event_time,
    input  logic                                    cfg_valid,
    input  logic [pgr_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [pgr_pkg::CFG_DATA_BITS-1:0]       cfg_data,
    input  pgr_pkg::q_status_t                      q_status,
    output logic                                    push,
    output logic [pgr_pkg::entry_bits(COORD_BITS)-1:0] push_data
);
    import pgr_pkg::*;

    typedef struct packed {
        logic [2:0]            gesture;
        logic [1:0]            btn;
        logic                  dbl;
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
    } res_t;

    typedef struct packed {
        logic                  two;
        res_t                  r0;
        res_t                  r1;
        logic [COORD_BITS-1:0] ex;
        logic [COORD_BITS-1:0] ey;
    } entry_t;

    // configuration
    logic [15:0] double_window_reg;
    logic [7:0]  double_box_reg;
    logic [7:0]  drag_distance_reg;
    logic [15:0] repeat_delay_reg;
    logic [15:0] repeat_period_reg;

    // gesture state
    logic                  pressed_reg, pressed_next;
    logic                  dragging_reg, dragging_next;
    logic                  ignore_reg, ignore_next;
    logic [1:0]            held_reg, held_next;
    logic [TIME_BITS-1:0]  ptime_reg, ptime_next;
    logic [COORD_BITS-1:0] px_reg, px_next;
    logic [COORD_BITS-1:0] py_reg, py_next;
    logic                  dbl_reg, dbl_next;
    logic                  armed_reg, armed_next;
    logic                  started_reg, started_next;
    logic [15:0]           rcount_reg, rcount_next;

    logic                  s_fire;
    logic [COORD_BITS-1:0] adx, ady, box_ext, drag_ext;
    logic [TIME_BITS-1:0]  dt, window_ext;
    logic                  new_dbl, far_move;
    logic [15:0]           rcount_inc, rthresh;
    entry_t                entry;

    assign s_tready = !q_status.full;
    assign s_fire   = s_tvalid && s_tready;

    assign adx = (x_position > px_reg) ? x_position - px_reg : px_reg - x_position;
    assign ady = (y_position > py_reg) ? y_position - py_reg : py_reg - y_position;
    assign box_ext    = COORD_BITS'(double_box_reg);
    assign drag_ext   = COORD_BITS'(drag_distance_reg);
    assign dt         = event_time - ptime_reg;
    assign window_ext = TIME_BITS'(double_window_reg);

    // a press during a drag is never a double, as new_dbl requires that no drag is in progress
    assign new_dbl = !dragging_reg && (button == held_reg) && (ptime_reg != '0)
                     && (dt <= window_ext) && (adx <= box_ext) && (ady <= box_ext);
    assign far_move = (adx >= drag_ext) || (ady >= drag_ext);

    assign rcount_inc = (rcount_reg == 16'hFFFF) ? rcount_reg : rcount_reg + 16'd1;
    assign rthresh    = started_reg ? repeat_period_reg : repeat_delay_reg;

    always_comb begin
        pressed_next  = pressed_reg;
        dragging_next = dragging_reg;
        ignore_next   = ignore_reg;
        held_next     = held_reg;
        ptime_next    = ptime_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        dbl_next      = dbl_reg;
        armed_next    = armed_reg;
        started_next  = started_reg;
        rcount_next   = rcount_reg;
        push          = 1'b0;
        entry         = '0;
        entry.ex      = x_position;
        entry.ey      = y_position;
        entry.r0.btn  = held_reg;
        entry.r0.dbl  = dbl_reg;
        entry.r0.sx   = px_reg;
        entry.r0.sy   = py_reg;
        if (s_fire) begin
            case (command)
                CMD_PRESS: begin
                    if (ignore_reg) begin
                        ignore_next = 1'b0;
                    end else begin
                        push          = 1'b1;
                        armed_next    = 1'b1;
                        started_next  = 1'b0;
                        rcount_next   = '0;
                        dbl_next      = new_dbl;
                        pressed_next  = 1'b1;
                        dragging_next = 1'b0;
                        held_next     = button;
                        ptime_next    = event_time;
                        px_next       = x_position;
                        py_next       = y_position;
                        if (dragging_reg) begin
                            entry.two        = 1'b1;
                            entry.r0.gesture = G_DRAG_CANCEL;
                            entry.r1.gesture = G_PRESS;
                            entry.r1.btn     = button;
                            entry.r1.dbl     = new_dbl;
                            entry.r1.sx      = x_position;
                            entry.r1.sy      = y_position;
                        end else begin
                            entry.r0.gesture = G_PRESS;
                            entry.r0.btn     = button;
                            entry.r0.dbl     = new_dbl;
                            entry.r0.sx      = x_position;
                            entry.r0.sy      = y_position;
                        end
                    end
                end
                CMD_RELEASE: begin
                    if (pressed_reg && button == held_reg) begin
                        push             = 1'b1;
                        armed_next       = 1'b0;
                        pressed_next     = 1'b0;
                        entry.r0.gesture = dragging_reg ? G_DROP : G_CLICK;
                        if (dragging_reg) begin
                            dragging_next = 1'b0;
                            ptime_next    = '0;
                        end
                    end
                end
                CMD_MOVE: begin
                    if (pressed_reg && !dragging_reg && far_move) begin
                        push             = 1'b1;
                        armed_next       = 1'b0;
                        dragging_next    = 1'b1;
                        entry.r0.gesture = G_DRAG_START;
                    end
                end
                CMD_TICK: begin
                    if (armed_reg) begin
                        rcount_next = rcount_inc;
                        if (rcount_inc >= rthresh) begin
                            push             = 1'b1;
                            started_next     = 1'b1;
                            rcount_next      = '0;
                            entry.r0.gesture = G_REPEAT;
                        end
                    end
                end
                CMD_CANCEL: begin
                    if (dragging_reg) begin
                        push             = 1'b1;
                        entry.r0.gesture = G_DRAG_CANCEL;
                    end
                    dragging_next = 1'b0;
                    armed_next    = 1'b0;
                    pressed_next  = 1'b0;
                    ptime_next    = '0;
                end
                CMD_IGNORE: begin
                    ignore_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign push_data = entry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            double_window_reg <= DOUBLE_WINDOW_RST;
            double_box_reg    <= DOUBLE_BOX_RST;
            drag_distance_reg <= DRAG_DISTANCE_RST;
            repeat_delay_reg  <= REPEAT_DELAY_RST;
            repeat_period_reg <= REPEAT_PERIOD_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DOUBLE_WINDOW: double_window_reg <= cfg_data;
                CFG_DOUBLE_BOX:    double_box_reg    <= cfg_data[7:0];
                CFG_DRAG_DISTANCE: drag_distance_reg <= cfg_data[7:0];
                CFG_REPEAT_DELAY:  repeat_delay_reg  <= cfg_data;
                CFG_REPEAT_PERIOD: repeat_period_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressed_reg  <= 1'b0;
            dragging_reg <= 1'b0;
            ignore_reg   <= 1'b0;
            held_reg     <= '0;
            ptime_reg    <= '0;
            px_reg       <= '0;
            py_reg       <= '0;
            dbl_reg      <= 1'b0;
            armed_reg    <= 1'b0;
            started_reg  <= 1'b0;
            rcount_reg   <= '0;
        end else begin
            pressed_reg  <= pressed_next;
            dragging_reg <= dragging_next;
            ignore_reg   <= ignore_next;
            held_reg     <= held_next;
            ptime_reg    <= ptime_next;
            px_reg       <= px_next;
            py_reg       <= py_next;
            dbl_reg      <= dbl_next;
            armed_reg    <= armed_next;
            started_reg  <= started_next;
            rcount_reg   <= rcount_next;
        end
    end

`ifndef ASSERT_OFF
    a_drag_needs_press: assert property (@(posedge aclk) disable iff (!aresetn)
        dragging_reg |-> pressed_reg)
        else $error("dragging without a held button");
    a_ignored_press: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && command == CMD_PRESS && ignore_reg) |-> !push ##1 !ignore_reg)
        else $error("ignored press produced a result");
    a_two_only_press: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && entry.two) |-> (command == CMD_PRESS && dragging_reg))
        else $error("two results outside press during drag");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_status.full)
        else $error("push into full queue");
`endif

endmodule

// ----- rtl/pgr_back.sv -----
module pgr_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  pgr_pkg::q_status_t                      q_status,
    input  logic [pgr_pkg::entry_bits(COORD_BITS)-1:0] pop_data,
    output logic                                    pop,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic                                    m_tlast,
    output logic [2:0]                              gesture,
    output logic [1:0]                              which_button,
    output logic                                    is_double,
    output logic [COORD_BITS-1:0]                   start_x,
    output logic [COORD_BITS-1:0]                   start_y,
    output logic [COORD_BITS-1:0]                   end_x,
    output logic [COORD_BITS-1:0]                   end_y
);
    import pgr_pkg::*;

    typedef struct packed {
        logic [2:0]            gesture;
        logic [1:0]            btn;
        logic                  dbl;
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
    } res_t;

    typedef struct packed {
        logic                  two;
        res_t                  r0;
        res_t                  r1;
        logic [COORD_BITS-1:0] ex;
        logic [COORD_BITS-1:0] ey;
    } entry_t;

    entry_t                entry;
    entry_t                hold_reg;
    logic                  second_reg;
    logic                  m_tvalid_reg;
    logic                  m_tlast_reg;
    res_t                  out_reg;
    logic [COORD_BITS-1:0] ex_reg, ey_reg;
    logic                  load_ok;

    assign entry   = pop_data;
    assign load_ok = !m_tvalid_reg || m_tready;
    // the second result of an item goes out before the next entry is taken
    assign pop     = load_ok && !second_reg && !q_status.empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            second_reg   <= 1'b0;
        end else if (load_ok) begin
            if (second_reg) begin
                m_tvalid_reg <= 1'b1;
                second_reg   <= 1'b0;
            end else if (!q_status.empty) begin
                m_tvalid_reg <= 1'b1;
                second_reg   <= entry.two;
            end else begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_ok) begin
            if (second_reg) begin
                out_reg     <= hold_reg.r1;
                m_tlast_reg <= 1'b1;
                ex_reg      <= hold_reg.ex;
                ey_reg      <= hold_reg.ey;
            end else if (!q_status.empty) begin
                out_reg     <= entry.r0;
                m_tlast_reg <= !entry.two;
                ex_reg      <= entry.ex;
                ey_reg      <= entry.ey;
                hold_reg    <= entry;
            end
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign m_tlast      = m_tlast_reg;
    assign gesture      = out_reg.gesture;
    assign which_button = out_reg.btn;
    assign is_double    = out_reg.dbl;
    assign start_x      = out_reg.sx;
    assign start_y      = out_reg.sy;
    assign end_x        = ex_reg;
    assign end_y        = ey_reg;

`ifndef ASSERT_OFF
    a_second_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tready && !m_tlast_reg) |=> (m_tvalid_reg && m_tlast_reg))
        else $error("second result of item did not follow");
    a_second_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        second_reg |-> (m_tvalid_reg && !m_tlast_reg))
        else $error("pending second result without first shown");
    a_no_pop_second: assert property (@(posedge aclk) disable iff (!aresetn)
        second_reg |-> !pop)
        else $error("entry taken while second result pending");
`endif

endmodule
